@@ src/packed_pattern_note_unpacker_defines.svh @@
// assertion macros for the packed pattern note unpacker
`ifndef PACKED_PATTERN_NOTE_UNPACKER_DEFINES_SVH
`define PACKED_PATTERN_NOTE_UNPACKER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PPNU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PPNU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ppnu_pkg.sv @@
// shared types, codes and period table of the note unpacker
`timescale 1ns / 1ps

package ppnu_pkg;

    localparam logic [7:0] LEAD_EMPTY  = 8'h80;
    localparam logic [7:0] LEAD_REPEAT = 8'hC0;
    localparam int unsigned STANDARD_ENTRIES = 37;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_SECOND,
        PH_THIRD
    } phase_t;

    typedef enum logic [1:0] {
        KIND_EMPTY,
        KIND_REPEAT,
        KIND_FULL
    } kind_t;

    // one classified entry as it waits in the queue
    typedef struct packed {
        kind_t      kind;
        logic [7:0] lead;
        logic [7:0] second;
        logic [7:0] param;
    } entry_t;

    // one unpacked note as kept per voice
    typedef struct packed {
        logic [4:0]  sample;
        logic [11:0] period;
        logic [3:0]  cmd;
        logic [7:0]  param;
    } note_t;

    // standard tracker period table, zero at index zero and past the last entry
    function automatic logic [11:0] period_lookup(input logic [6:0] idx);
        logic [11:0] per;
        case (idx)
            7'd1:  per = 12'd856;
            7'd2:  per = 12'd808;
            7'd3:  per = 12'd762;
            7'd4:  per = 12'd720;
            7'd5:  per = 12'd678;
            7'd6:  per = 12'd640;
            7'd7:  per = 12'd604;
            7'd8:  per = 12'd570;
            7'd9:  per = 12'd538;
            7'd10: per = 12'd508;
            7'd11: per = 12'd480;
            7'd12: per = 12'd453;
            7'd13: per = 12'd428;
            7'd14: per = 12'd404;
            7'd15: per = 12'd381;
            7'd16: per = 12'd360;
            7'd17: per = 12'd339;
            7'd18: per = 12'd320;
            7'd19: per = 12'd302;
            7'd20: per = 12'd285;
            7'd21: per = 12'd269;
            7'd22: per = 12'd254;
            7'd23: per = 12'd240;
            7'd24: per = 12'd226;
            7'd25: per = 12'd214;
            7'd26: per = 12'd202;
            7'd27: per = 12'd190;
            7'd28: per = 12'd180;
            7'd29: per = 12'd170;
            7'd30: per = 12'd160;
            7'd31: per = 12'd151;
            7'd32: per = 12'd143;
            7'd33: per = 12'd135;
            7'd34: per = 12'd127;
            7'd35: per = 12'd120;
            7'd36: per = 12'd113;
            default: per = 12'd0;
        endcase
        return per;
    endfunction

endpackage

@@ src/packed_pattern_note_unpacker.sv @@
// top level of the packed pattern note unpacker
`timescale 1ns / 1ps

// takes the packed pattern stream one beat per byte and gives one note beat
// per entry: 0x80 gives an empty note, 0xc0 repeats the last full note of the
// current voice, any other lead byte is followed by two more bytes and forms a
// full note whose period comes from the standard tracker period table; note
// indexes at or past PERIOD_ENTRIES give period zero with bad_note set. the
// voice counts 0 to VOICES-1 over entries and the channel port carries its
// low two bits. a byte is taken every cycle while the queue is not full; a
// completed entry is written into the two-entry queue and then into the
// builder's output register, which gives the note beat. the gatherer only
// stalls when the queue is full, which happens only while the note side holds
// off ready, so the sustained rate is one byte per clock.

`include "packed_pattern_note_unpacker_defines.svh"

module packed_pattern_note_unpacker
    import ppnu_pkg::*;
#(
    parameter int VOICES         = 4,
    parameter int PERIOD_ENTRIES = 37
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [7:0]  data_byte,
    output logic        note_valid,
    input  logic        note_ready,
    output logic [1:0]  channel,
    output logic [4:0]  sample_number,
    output logic [11:0] period,
    output logic [3:0]  effect_command,
    output logic [7:0]  effect_param,
    output logic        bad_note
);

    // voice index width, at least one bit
    localparam int CH_W    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int ENTRY_W = $bits(entry_t) + CH_W;

    logic            q_push;
    logic            q_pop;
    logic            q_empty;
    logic            q_full;
    entry_t          push_entry;
    logic [CH_W-1:0] push_ch;
    entry_t          pop_entry;
    logic [CH_W-1:0] pop_ch;
    logic [ENTRY_W-1:0] q_wdata;
    logic [ENTRY_W-1:0] q_rdata;

    // front: gather bytes into entries and tag each with its voice
    ppnu_front #(
        .VOICES (VOICES),
        .CH_W   (CH_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (data_valid),
        .byte_data  (data_byte),
        .q_full     (q_full),
        .byte_ready (data_ready),
        .push       (q_push),
        .push_entry (push_entry),
        .push_ch    (push_ch)
    );

    assign q_wdata = {push_entry, push_ch};

    // decoupling queue
    ppnu_queue #(
        .W (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty),
        .full      (q_full)
    );

    assign {pop_entry, pop_ch} = q_rdata;

    // back: build the note, keep per-voice history, hold the output beat
    ppnu_back #(
        .VOICES         (VOICES),
        .PERIOD_ENTRIES (PERIOD_ENTRIES),
        .CH_W           (CH_W)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_entry        (pop_entry),
        .q_ch           (pop_ch),
        .pop            (q_pop),
        .note_valid     (note_valid),
        .note_ready     (note_ready),
        .channel        (channel),
        .sample_number  (sample_number),
        .period         (period),
        .effect_command (effect_command),
        .effect_param   (effect_param),
        .bad_note       (bad_note)
    );

    // queue never overflows or underflows
    `PPNU_ASSERT_NOW(a_no_push_full, clk, rst_n, q_push, !q_full, "push into full queue")
    `PPNU_ASSERT_NOW(a_no_pop_empty, clk, rst_n, q_pop, !q_empty, "pop from empty queue")
    // an out-of-table note never carries a period
    `PPNU_ASSERT_NOW(a_bad_no_period, clk, rst_n, note_valid && bad_note, period == 12'd0,
        "bad note with nonzero period")
    // a pop always lands in the output register
    `PPNU_ASSERT_NEXT(a_pop_valid, clk, rst_n, q_pop, note_valid, "popped entry not shown")

endmodule

@@ src/ppnu_front.sv @@
// byte gatherer: collects entries, classifies them and tags the voice
`timescale 1ns / 1ps

module ppnu_front
    import ppnu_pkg::*;
#(
    parameter int VOICES = 4,
    parameter int CH_W   = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_valid,
    input  logic [7:0]      byte_data,
    input  logic            q_full,
    output logic            byte_ready,
    output logic            push,
    output entry_t          push_entry,
    output logic [CH_W-1:0] push_ch
);

    phase_t          phase_reg, phase_next;
    logic [7:0]      lead_reg, lead_next;
    logic [7:0]      second_reg, second_next;
    logic [CH_W-1:0] ch_reg, ch_next;
    logic            take;

    assign byte_ready = !q_full;
    assign take       = byte_valid && !q_full;
    assign push_ch    = ch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LEAD;
            lead_reg   <= '0;
            second_reg <= '0;
            ch_reg     <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            lead_reg   <= lead_next;
            second_reg <= second_next;
            ch_reg     <= ch_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        lead_next   = lead_reg;
        second_next = second_reg;
        push        = 1'b0;
        push_entry  = '{kind: KIND_EMPTY, lead: 8'd0, second: 8'd0, param: 8'd0};
        if (take)
        begin
            case (phase_reg)
                PH_SECOND:
                begin
                    second_next = byte_data;
                    phase_next  = PH_THIRD;
                end
                PH_THIRD:
                begin
                    push       = 1'b1;
                    push_entry = '{kind: KIND_FULL, lead: lead_reg,
                                   second: second_reg, param: byte_data};
                    phase_next = PH_LEAD;
                end
                default:
                begin
                    phase_next = PH_LEAD;
                    if (byte_data == LEAD_EMPTY)
                    begin
                        push = 1'b1;
                    end
                    else if (byte_data == LEAD_REPEAT)
                    begin
                        push            = 1'b1;
                        push_entry.kind = KIND_REPEAT;
                    end
                    else
                    begin
                        lead_next  = byte_data;
                        phase_next = PH_SECOND;
                    end
                end
            endcase
        end
    end

    // voice advances after every complete entry
    always_comb
    begin
        ch_next = ch_reg;
        if (push)
        begin
            if (ch_reg == CH_W'(VOICES - 1))
                ch_next = '0;
            else
                ch_next = ch_reg + 1'b1;
        end
    end

endmodule

@@ src/ppnu_queue.sv @@
// two-entry queue between the gatherer and the note builder
`timescale 1ns / 1ps

module ppnu_queue #(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty,
    output logic         full
);

    logic [W-1:0] slot_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;

    assign empty    = (count_reg == 2'd0);
    assign full     = (count_reg == 2'd2);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

@@ src/ppnu_back.sv @@
// note builder: period lookup, per-voice note store and output register
`timescale 1ns / 1ps

module ppnu_back
    import ppnu_pkg::*;
#(
    parameter int VOICES         = 4,
    parameter int PERIOD_ENTRIES = 37,
    parameter int CH_W           = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  entry_t          q_entry,
    input  logic [CH_W-1:0] q_ch,
    output logic            pop,
    output logic            note_valid,
    input  logic            note_ready,
    output logic [1:0]      channel,
    output logic [4:0]      sample_number,
    output logic [11:0]     period,
    output logic [3:0]      effect_command,
    output logic [7:0]      effect_param,
    output logic            bad_note
);

    note_t      store_reg [VOICES];
    logic       valid_reg, valid_next;
    note_t      note_reg, note_next;
    logic [1:0] ch_reg;
    logic       bad_reg, bad_next;
    note_t      full_note;
    logic [6:0] idx;
    logic       idx_bad;

    assign pop = !q_empty && (!valid_reg || note_ready);

    assign idx     = q_entry.lead[7:1];
    assign idx_bad = (idx >= 7'(PERIOD_ENTRIES));

    always_comb
    begin
        full_note.sample = {q_entry.second[7], q_entry.second[6:4], q_entry.lead[0]};
        full_note.period = idx_bad ? 12'd0 : period_lookup(idx);
        full_note.cmd    = q_entry.second[3:0];
        full_note.param  = q_entry.param;
    end

    always_comb
    begin
        valid_next = valid_reg && !note_ready;
        note_next  = note_reg;
        bad_next   = bad_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            case (q_entry.kind)
                KIND_FULL:
                begin
                    note_next = full_note;
                    bad_next  = idx_bad;
                end
                KIND_REPEAT:
                begin
                    note_next = store_reg[q_ch];
                    bad_next  = 1'b0;
                end
                default:
                begin
                    note_next = '0;
                    bad_next  = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            for (int v = 0; v < VOICES; v++)
                store_reg[v] <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (pop && q_entry.kind == KIND_FULL)
                store_reg[q_ch] <= full_note;
        end
    end

    always_ff @(posedge clk)
    begin
        note_reg <= note_next;
        bad_reg  <= bad_next;
        if (pop)
            ch_reg <= 2'(q_ch);
    end

    assign note_valid     = valid_reg;
    assign channel        = ch_reg;
    assign sample_number  = note_reg.sample;
    assign period         = note_reg.period;
    assign effect_command = note_reg.cmd;
    assign effect_param   = note_reg.param;
    assign bad_note       = bad_reg;

endmodule
